[src/dtf_pkg.sv]
// Shared types, character codes and the power-of-ten table for the decimal
// text formatter. No dependencies; compile first.
package dtf_pkg;

  typedef logic [7:0] char_t;

  // Formatter sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PAD,
    ST_SIGN,
    ST_SUB,
    ST_LAST
  } dtf_state_t;

  localparam int unsigned DEF_MAX_WIDTH = 32;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned FIELD_W       = 6;

  localparam char_t PAD_RESET  = 8'd32;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_MINUS = 8'h2D;

  // Power of ten for leading digit position idx (10000 down to 10)
  function automatic logic [VALUE_W-1:0] pow_ten(input logic [1:0] idx);
    logic [VALUE_W-1:0] p;
    case (idx)
      2'd0:    p = 16'd10000;
      2'd1:    p = 16'd1000;
      2'd2:    p = 16'd100;
      default: p = 16'd10;
    endcase
    return p;
  endfunction

endpackage

[src/dtf_in_if.sv]
// Input channel of the decimal text formatter: valid/ready plus the number,
// its mode and its field width. Depends on dtf_pkg.
interface dtf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [dtf_pkg::VALUE_W-1:0]  value;
  logic [dtf_pkg::FIELD_W-1:0]  field_width;

  modport source (output valid, cmd, value, field_width, input ready);
  modport sink   (input valid, cmd, value, field_width, output ready);
endinterface

[src/dtf_out_if.sv]
// Result channel of the decimal text formatter: one ASCII character per item
// with a last flag. Depends on dtf_pkg.
interface dtf_out_if;
  logic            valid;
  logic            ready;
  dtf_pkg::char_t  out_char;
  logic            last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

[src/decimal_text_formatter.sv]
// Top level of the decimal text formatter: sequencer, repeated-subtraction
// digit unit and output register. Depends on dtf_pkg, dtf_in_if, dtf_out_if.
//
// Usage:
//   in_ch  : one number per item (cmd 0 unsigned, 1 signed; value; field_width).
//   out_ch : one ASCII character per item, last set on the final digit.
//   cfg_we / cfg_wdata : write the pad character (reset value is a space).
// Each number yields its padding, an optional minus sign and its digits,
// one character per cycle while out_ch is ready and no digit is being found.
// Leading digits are found by subtracting a power of ten once per cycle and
// counting the subtractions; the units digit is what remains.
// An item is accepted, then prepared, then its pads, sign and digits follow;
// in_ch.ready is high only between numbers. The final character sits in the
// output register while the next number is accepted.
// Reset clears the sequencer and the output register and sets the pad
// character to a space. When out_ch stalls, the held character stays and the
// sequencer waits; no character is dropped or repeated.
module decimal_text_formatter #(
  parameter int unsigned MAX_WIDTH = dtf_pkg::DEF_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  dtf_in_if.sink             in_ch,
  dtf_out_if.source          out_ch,
  input  logic               cfg_we,
  input  dtf_pkg::char_t     cfg_wdata
);
  import dtf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (PW > FIELD_W) ? PW : FIELD_W;

  dtf_state_t          state_r, state_nxt;
  char_t               pad_r;
  logic                neg_r;
  logic                multi_r;
  logic [VALUE_W-1:0]  mag_r;
  logic [CW-1:0]       width_r;
  logic [CW-1:0]       pad_cnt_r;
  logic [1:0]          idx_r;
  logic [3:0]          dig_r;
  logic                out_valid_r;
  char_t               out_char_r;
  logic                out_last_r;

  logic                in_acc;
  logic                out_free;
  logic                emit;
  char_t               emit_char;
  logic                emit_last;
  logic                sub_ok;
  logic [2:0]          nd;
  logic [2:0]          len;
  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       fw_ext;
  logic [CW-1:0]       pad_calc;
  logic [VALUE_W-1:0]  pow_cur;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

  // Digit count, text length and pad count of the held magnitude
  always_comb begin
    nd = 3'd1;
    if (mag_r >= 16'd10)    nd = 3'd2;
    if (mag_r >= 16'd100)   nd = 3'd3;
    if (mag_r >= 16'd1000)  nd = 3'd4;
    if (mag_r >= 16'd10000) nd = 3'd5;
    len     = nd + {2'b00, neg_r};
    len_ext = CW'(len);
    pad_calc = (width_r > len_ext) ? (width_r - len_ext) : '0;
  end

  assign fw_ext  = CW'(in_ch.field_width);
  assign pow_cur = pow_ten(idx_r);
  assign sub_ok  = (mag_r >= pow_cur);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (pad_calc != '0)  state_nxt = ST_PAD;
        else if (neg_r)      state_nxt = ST_SIGN;
        else if (nd > 3'd1)  state_nxt = ST_SUB;
        else                 state_nxt = ST_LAST;
      end
      ST_PAD: begin
        if (out_free && pad_cnt_r == CW'(1)) begin
          if (neg_r)        state_nxt = ST_SIGN;
          else if (multi_r) state_nxt = ST_SUB;
          else              state_nxt = ST_LAST;
        end
      end
      ST_SIGN: begin
        if (out_free) state_nxt = multi_r ? ST_SUB : ST_LAST;
      end
      ST_SUB: begin
        if (!sub_ok && out_free && idx_r == 2'd3) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Character offered to the output register
  always_comb begin
    emit      = 1'b0;
    emit_char = pad_r;
    emit_last = 1'b0;
    unique case (state_r)
      ST_PAD: begin
        emit      = out_free;
        emit_char = pad_r;
      end
      ST_SIGN: begin
        emit      = out_free;
        emit_char = CHAR_MINUS;
      end
      ST_SUB: begin
        emit      = out_free && !sub_ok;
        emit_char = CHAR_ZERO + {4'd0, dig_r};
      end
      ST_LAST: begin
        emit      = out_free;
        emit_char = CHAR_ZERO + {4'd0, mag_r[3:0]};
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer state and pad register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pad_r   <= PAD_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) pad_r <= cfg_wdata;
    end
  end

  // Datapath: capture, prepare, count pads, subtract powers of ten
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          neg_r   <= in_ch.cmd && in_ch.value[VALUE_W-1];
          mag_r   <= (in_ch.cmd && in_ch.value[VALUE_W-1]) ? (~in_ch.value + 16'd1)
                                                           : in_ch.value;
          width_r <= (fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext;
        end
      end
      ST_PREP: begin
        pad_cnt_r <= pad_calc;
        multi_r   <= (nd > 3'd1);
        idx_r     <= 2'(3'd5 - nd);
        dig_r     <= 4'd0;
      end
      ST_PAD: begin
        if (out_free) pad_cnt_r <= pad_cnt_r - CW'(1);
      end
      ST_SUB: begin
        if (sub_ok) begin
          mag_r <= mag_r - pow_cur;
          dig_r <= dig_r + 4'd1;
        end else if (out_free) begin
          dig_r <= 4'd0;
          idx_r <= idx_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    dig_r <= 4'd9 || state_r != ST_SUB)
    else $error("digit counter exceeded nine");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PAD |-> pad_cnt_r != '0)
    else $error("pad state with zero pad count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("ready held after accepting an item");
`endif

endmodule

[dv/dtf_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the decimal text formatter. It watches both channels and the pad
// register port, predicts the characters of each number and compares them.
// Depends on dtf_pkg, dtf_in_if and dtf_out_if.
module dtf_checker #(
  parameter int unsigned MAX_WIDTH = dtf_pkg::DEF_MAX_WIDTH
) (
  input  logic            clk,
  input  logic            rst_n,
  dtf_in_if               in_mon,
  dtf_out_if              out_mon,
  input  logic            cfg_we,
  input  dtf_pkg::char_t  cfg_wdata,
  output int unsigned     fail_count,
  output int unsigned     pending,
  output int unsigned     numbers_seen,
  output int unsigned     chars_seen
);
  import dtf_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_char_t;

  text_char_t expected_text[$];
  char_t      pad_char;

  task automatic report_fault(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Append the padding, sign and digits one number should produce
  function automatic void queue_number_text(input logic signed_mode,
                                            input logic [VALUE_W-1:0] number,
                                            input logic [FIELD_W-1:0] req_width);
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
    char_t              digit_text[5];
    int unsigned        n_digits;
    int unsigned        text_len;
    int unsigned        field;
    int unsigned        k;
    negative  = signed_mode && number[VALUE_W-1];
    magnitude = negative ? (~number + 1'b1) : number;
    // digits come out least significant first
    n_digits = 0;
    do begin
      digit_text[n_digits] = CHAR_ZERO + char_t'(magnitude % 10);
      magnitude = VALUE_W'(magnitude / 10);
      n_digits++;
    end while (magnitude != 0);
    text_len = n_digits + (negative ? 1 : 0);
    field    = (req_width > MAX_WIDTH) ? MAX_WIDTH : req_width;
    for (k = text_len; k < field; k++) begin
      expected_text.push_back('{ch: pad_char, last: 1'b0});
    end
    if (negative) begin
      expected_text.push_back('{ch: CHAR_MINUS, last: 1'b0});
    end
    for (k = n_digits; k > 0; k--) begin
      expected_text.push_back('{ch: digit_text[k-1], last: (k == 1)});
    end
  endfunction

  // Check the outgoing character first: it belongs to an earlier number than
  // any item accepted at the same edge
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      pad_char     = PAD_RESET;
      fail_count   = 0;
      numbers_seen = 0;
      chars_seen   = 0;
      expected_text.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          report_fault($sformatf("character 0x%02h last %0b with nothing outstanding",
                                 out_mon.out_char, out_mon.last));
        end else begin
          want = expected_text.pop_front();
          if (out_mon.out_char !== want.ch)
            report_fault($sformatf("character %0d: got 0x%02h, want 0x%02h",
                                   chars_seen, out_mon.out_char, want.ch));
          if (out_mon.last !== want.last)
            report_fault($sformatf("character %0d: last got %b, want %b",
                                   chars_seen, out_mon.last, want.last));
        end
      end
      if (cfg_we) begin
        pad_char = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        numbers_seen++;
        queue_number_text(in_mon.cmd, in_mon.value, in_mon.field_width);
      end
    end
    pending = expected_text.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the decimal text formatter testbench: clock, reset, number stimulus,
// receiver stalls and the verdict. Depends on dtf_pkg, both channel interfaces,
// decimal_text_formatter and dtf_checker.
module tb_top;
  import dtf_pkg::*;

  localparam int unsigned MAX_WIDTH     = DEF_MAX_WIDTH;
  localparam logic        MODE_UNSIGNED = 1'b0;
  localparam logic        MODE_SIGNED   = 1'b1;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 80;
  localparam int unsigned STALL_LIMIT   = 3000;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  char_t cfg_wdata;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned numbers_seen;
  int unsigned chars_seen;

  dtf_in_if  in_ch ();
  dtf_out_if out_ch ();

  decimal_text_formatter #(.MAX_WIDTH(MAX_WIDTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dtf_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .numbers_seen (numbers_seen),
    .chars_seen   (chars_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one number, with a random gap first; return at the falling edge after
  // it is taken so the next item can follow without valid dropping
  task automatic send_number(input logic mode, input logic [VALUE_W-1:0] number,
                             input logic [FIELD_W-1:0] width);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= mode;
    in_ch.value       <= number;
    in_ch.field_width <= width;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly short fields and a spread of digit counts, with the edges of the
  // signed range visited often
  task automatic send_random_number();
    int unsigned        pick;
    logic [VALUE_W-1:0] number;
    logic [FIELD_W-1:0] width;
    pick = $urandom_range(0, 99);
    if (pick < 30)      number = VALUE_W'($urandom);
    else if (pick < 40) number = VALUE_W'($urandom_range(0, 9));
    else if (pick < 50) number = VALUE_W'($urandom_range(10, 99));
    else if (pick < 60) number = VALUE_W'($urandom_range(100, 999));
    else if (pick < 70) number = VALUE_W'($urandom_range(1000, 9999));
    else if (pick < 80) number = VALUE_W'($urandom_range(10000, 65535));
    else if (pick < 90) number = VALUE_W'(32'h8000 + $urandom_range(0, 7) - 32'd4);
    else                number = VALUE_W'(32'hFFFF - $urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 75)      width = FIELD_W'($urandom_range(0, 8));
    else if (pick < 95) width = FIELD_W'($urandom_range(9, 40));
    else                width = FIELD_W'($urandom_range(41, 63));
    send_number($urandom_range(0, 1) ? MODE_SIGNED : MODE_UNSIGNED, number, width);
  endtask

  // Drop valid and let every outstanding character drain before a register write
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_pad(input char_t pad);
    cfg_we    <= 1'b1;
    cfg_wdata <= pad;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = MODE_UNSIGNED;
    in_ch.value       = '0;
    in_ch.field_width = '0;
    out_ch.ready      = 1'b0;
    hold_request      = 1'b0;
    hold_left         = 0;
    quiet_cycles      = 0;
    tx_idle_pct       = 32;
    rx_idle_pct       = 79;

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed extremes with the reset pad character
    send_number(MODE_UNSIGNED, 16'd0,     6'd0);
    send_number(MODE_UNSIGNED, 16'hFFFF,  6'd0);
    send_number(MODE_UNSIGNED, 16'hFFFF,  6'd5);
    send_number(MODE_UNSIGNED, 16'hFFFF,  6'd6);
    send_number(MODE_SIGNED,   16'h8000,  6'd0);
    send_number(MODE_SIGNED,   16'h8000,  6'd7);
    send_number(MODE_SIGNED,   16'h7FFF,  6'd0);
    send_number(MODE_SIGNED,   16'h7FFF,  6'd6);
    send_number(MODE_SIGNED,   16'hFFFF,  6'd2);
    send_number(MODE_SIGNED,   16'd0,     6'd1);
    send_number(MODE_UNSIGNED, 16'd1,     6'd32);
    send_number(MODE_UNSIGNED, 16'd7,     6'd33);
    send_number(MODE_UNSIGNED, 16'd42,    6'd63);
    send_number(MODE_SIGNED,   16'hFFF6,  6'd6);
    send_number(MODE_UNSIGNED, 16'd10000, 6'd0);
    send_number(MODE_UNSIGNED, 16'd9999,  6'd4);
    send_number(MODE_UNSIGNED, 16'd100,   6'd2);
    send_number(MODE_UNSIGNED, 16'd10,    6'd0);
    send_number(MODE_SIGNED,   16'd5,     6'd3);
    send_number(MODE_SIGNED,   16'h8001,  6'd32);

    // Sender idles lightly, receiver heavily; pad with NUL
    wait_drained();
    write_pad(8'h00);
    repeat (PHASE_ITEMS) send_random_number();

    // Swap the idling; pad with all ones
    wait_drained();
    tx_idle_pct = 79;
    rx_idle_pct = 32;
    write_pad(8'hFF);
    repeat (PHASE_ITEMS) send_random_number();

    // No idling, a random pad and one long receiver hold-off to back up the input
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_pad(char_t'($urandom_range(0, 255)));
    hold_request = 1'b1;
    repeat (PHASE_ITEMS) send_random_number();

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    $display("Formatted %0d numbers into %0d characters, signed and unsigned,",
             numbers_seen, chars_seen);
    $display("with four pad settings, three idling mixes and one long output stall.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
